[src/bam_pkg.sv]
package bam_pkg;

   // configuration register indexes
   localparam int CSR_AW = 2;
   localparam logic [CSR_AW-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_AW-1:0] REG_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_AW-1:0] REG_BLOCK_SIZE   = 2'd2;

   localparam int CSR_DW   = 13;
   localparam int DIM_W    = 13;
   localparam int BSIZE_W  = 7;
   localparam int PIXEL_W  = 8;
   localparam int INDEX_W  = 12;
   localparam int HEIGHT_MAX = 4096;

   localparam logic [DIM_W-1:0]   WIDTH_RESET  = 13'd640;
   localparam logic [DIM_W-1:0]   HEIGHT_RESET = 13'd480;
   localparam logic [BSIZE_W-1:0] BSIZE_RESET  = 7'd8;

   typedef struct packed {
      logic accept;     // take the pixel, read its column sum, step counters
      logic acc;        // add pixel into column sum and write it back
      logic div_start;  // block closed: start the mean division
      logic load_out;   // move the quotient into the result register
   } bam_cmd_type;

   typedef struct packed {
      logic blk_end;    // captured pixel closes a block
      logic div_done;
      logic out_free;   // result register empty or being drained
   } bam_stat_type;

endpackage

[src/bam_div.sv]
module bam_div #(
   parameter int SUM_W = 22,
   parameter int DVW   = 14
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [SUM_W-1:0] dividend,
   input  logic [DVW-1:0]   divisor,
   output logic             done,
   output logic [SUM_W-1:0] quotient
);

   localparam int CW = $clog2(SUM_W + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic [SUM_W-1:0] quot_ff, quot_in;
   logic [DVW-1:0]   rem_ff, rem_in;
   logic [DVW-1:0]   div_ff, div_in;
   logic [DVW:0]     shifted;
   logic [DVW:0]     diff;
   logic             ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      shifted = {rem_ff, quot_ff[SUM_W-1]};
      diff    = shifted - {1'b0, div_ff};
      ge      = (shifted >= {1'b0, div_ff});
      cnt_in  = cnt_ff;
      quot_in = quot_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      if (start) begin
         cnt_in  = CW'(SUM_W);
         quot_in = dividend;
         rem_in  = '0;
         div_in  = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         quot_in = {quot_ff[SUM_W-2:0], ge};
         rem_in  = ge ? diff[DVW-1:0] : shifted[DVW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
   end

   assign done     = (cnt_ff == '0);
   assign quotient = quot_ff;

endmodule

[src/bam_ctrl.sv]
module bam_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  bam_pkg::bam_stat_type stat,
   output bam_pkg::bam_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_READ = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   logic [1:0] state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.accept = 1'b1;
               state_in   = ST_READ;
            end
         end
         ST_READ: begin
            cmd.acc = 1'b1;
            if (stat.blk_end) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            if (stat.div_done && stat.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

[src/bam_dp.sv]
module bam_dp #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BLOCK = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bam_pkg::bam_cmd_type        cmd,
   output bam_pkg::bam_stat_type       stat,
   input  logic [bam_pkg::PIXEL_W-1:0] pixel,
   input  logic                        csr_we,
   input  logic [bam_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [bam_pkg::CSR_DW-1:0]  csr_wdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,
   output logic                        rsp_tlast
);

   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int WCMP  = (XW + 1 > bam_pkg::DIM_W) ? XW + 1 : bam_pkg::DIM_W;
   localparam int CB    = $clog2(MAX_BLOCK);
   localparam int BCMP  = (CB > bam_pkg::BSIZE_W) ? CB : bam_pkg::BSIZE_W;
   localparam int CNT_W = $clog2(MAX_BLOCK + 1);
   localparam int DVW   = 2 * CNT_W;
   localparam int SUM_W = bam_pkg::PIXEL_W + DVW;
   localparam int IW    = bam_pkg::INDEX_W;

   // configuration
   logic [bam_pkg::DIM_W-1:0]   width_ff, height_ff;
   logic [bam_pkg::BSIZE_W-1:0] bsize_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bam_pkg::WIDTH_RESET;
         height_ff <= bam_pkg::HEIGHT_RESET;
         bsize_ff  <= bam_pkg::BSIZE_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            bam_pkg::REG_IMAGE_WIDTH:  width_ff  <= csr_wdata;
            bam_pkg::REG_IMAGE_HEIGHT: height_ff <= csr_wdata;
            bam_pkg::REG_BLOCK_SIZE:   bsize_ff  <= csr_wdata[bam_pkg::BSIZE_W-1:0];
            default: ;
         endcase
      end
   end

   logic csr_hit;
   assign csr_hit = csr_we && (csr_addr == bam_pkg::REG_IMAGE_WIDTH ||
                               csr_addr == bam_pkg::REG_IMAGE_HEIGHT ||
                               csr_addr == bam_pkg::REG_BLOCK_SIZE);

   // clamped geometry
   logic [WCMP-1:0]             w_eff, w_last;
   logic [bam_pkg::DIM_W-1:0]   h_eff, h_last;
   logic [bam_pkg::BSIZE_W-1:0] bs_eff;
   logic [BCMP-1:0]             bs_last;

   always_comb begin
      w_eff = WCMP'(width_ff);
      if (w_eff == '0) begin
         w_eff = WCMP'(1);
      end else if (w_eff > WCMP'(MAX_WIDTH)) begin
         w_eff = WCMP'(MAX_WIDTH);
      end
      w_last = w_eff - 1'b1;

      h_eff = height_ff;
      if (h_eff == '0) begin
         h_eff = bam_pkg::DIM_W'(1);
      end else if (h_eff > bam_pkg::DIM_W'(bam_pkg::HEIGHT_MAX)) begin
         h_eff = bam_pkg::DIM_W'(bam_pkg::HEIGHT_MAX);
      end
      h_last = h_eff - 1'b1;

      bs_eff = bsize_ff;
      if (bs_eff == '0) begin
         bs_eff = bam_pkg::BSIZE_W'(1);
      end else if (int'(bs_eff) > MAX_BLOCK) begin
         bs_eff = bam_pkg::BSIZE_W'(MAX_BLOCK);
      end
      bs_last = BCMP'(bs_eff) - 1'b1;
   end

   // position counters
   logic [XW-1:0] px_ff, px_in, bx_ff, bx_in;
   logic [IW-1:0] py_ff, py_in, by_ff, by_in;
   logic [CB-1:0] cib_ff, cib_in, rib_ff, rib_in;
   logic          last_x, last_y, cib_top, rib_top;

   always_comb begin
      last_x  = (WCMP'(px_ff) >= w_last);
      last_y  = (bam_pkg::DIM_W'(py_ff) >= h_last);
      cib_top = (BCMP'(cib_ff) >= bs_last);
      rib_top = (BCMP'(rib_ff) >= bs_last);
      px_in  = px_ff;
      py_in  = py_ff;
      bx_in  = bx_ff;
      by_in  = by_ff;
      cib_in = cib_ff;
      rib_in = rib_ff;
      if (csr_hit) begin
         px_in  = '0;
         py_in  = '0;
         bx_in  = '0;
         by_in  = '0;
         cib_in = '0;
         rib_in = '0;
      end else if (cmd.accept) begin
         if (last_x) begin
            px_in  = '0;
            bx_in  = '0;
            cib_in = '0;
            if (last_y) begin
               py_in  = '0;
               by_in  = '0;
               rib_in = '0;
            end else begin
               py_in = py_ff + 1'b1;
               if (rib_top) begin
                  rib_in = '0;
                  by_in  = by_ff + 1'b1;
               end else begin
                  rib_in = rib_ff + 1'b1;
               end
            end
         end else begin
            px_in = px_ff + 1'b1;
            if (cib_top) begin
               cib_in = '0;
               bx_in  = bx_ff + 1'b1;
            end else begin
               cib_in = cib_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         px_ff  <= '0;
         py_ff  <= '0;
         bx_ff  <= '0;
         by_ff  <= '0;
         cib_ff <= '0;
         rib_ff <= '0;
      end else begin
         px_ff  <= px_in;
         py_ff  <= py_in;
         bx_ff  <= bx_in;
         by_ff  <= by_in;
         cib_ff <= cib_in;
         rib_ff <= rib_in;
      end
   end

   // captured pixel context
   logic [bam_pkg::PIXEL_W-1:0] pix_ff;
   logic [XW-1:0]               addr_ff;
   logic [IW-1:0]               bcol_ff, brow_ff;
   logic                        first_ff, end_ff, last_ff;
   logic [DVW-1:0]              count_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff   <= pixel;
         addr_ff  <= bx_ff;
         bcol_ff  <= IW'(bx_ff);
         brow_ff  <= by_ff;
         // the first pixel of a block starts its sum from zero, so the
         // column sums never need a clearing pass
         first_ff <= (cib_ff == '0) && (rib_ff == '0);
         end_ff   <= (cib_top || last_x) && (rib_top || last_y);
         last_ff  <= last_x && last_y;
         // pixels present = (column in block + 1) * (row in block + 1)
         count_ff <= (DVW'(cib_ff) + 1'b1) * (DVW'(rib_ff) + 1'b1);
      end
   end

   // column sum memory
   logic [SUM_W-1:0] sums_mem [MAX_WIDTH];
   logic [SUM_W-1:0] rd_ff;
   logic [SUM_W-1:0] sum_new;

   assign sum_new = (first_ff ? '0 : rd_ff) + SUM_W'(pix_ff);

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rd_ff <= sums_mem[bx_ff];
      end
      if (cmd.acc) begin
         sums_mem[addr_ff] <= sum_new;
      end
   end

   // mean
   logic             div_done;
   logic [SUM_W-1:0] quotient;

   bam_div #(
      .SUM_W (SUM_W),
      .DVW   (DVW)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_new),
      .divisor  (count_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // result register
   logic                        out_valid_ff;
   logic [bam_pkg::PIXEL_W-1:0] avg_ff;
   logic [IW-1:0]               ocol_ff, orow_ff;
   logic                        olast_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         avg_ff   <= quotient[bam_pkg::PIXEL_W-1:0];
         ocol_ff  <= bcol_ff;
         orow_ff  <= brow_ff;
         olast_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {orow_ff, ocol_ff, avg_ff};
   assign rsp_tlast  = olast_ff;

   assign stat.blk_end  = end_ff;
   assign stat.div_done = div_done;
   assign stat.out_free = !out_valid_ff || rsp_tready;

endmodule

[src/block_average_mosaic.sv]
// Block-average mosaic engine. 8-bit grayscale pixels come in on req_ in raster
// order; each finished block_size x block_size block gives one word on rsp_
// carrying its truncated mean, block column and block row, with rsp_tlast on
// the last block of the frame. Edge blocks are averaged over the pixels that
// are present. A pixel that does not close a block is accepted and its block
// column's running sum read, then the updated sum is written back in the
// single-port sum memory (MAX_WIDTH entries). A pixel that closes a block then
// waits in the bit-serial divider for its mean, and the quotient is loaded into
// the result register, which may then wait for rsp_tready while the next pixels
// are taken. The sum memory needs no clearing after reset: the first pixel of
// every block starts its sum from zero. Any write to a configuration register
// restarts the frame.
module block_average_mosaic #(
   parameter int MAX_WIDTH = 4096,
   parameter int MAX_BLOCK = 64
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [7:0]                  req_tdata,   // [7:0] pixel
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [31:0]                 rsp_tdata,   // [7:0] average, [19:8] block_column,
                                                    // [31:20] block_row
   output logic                        rsp_tlast,   // frame_done
   input  logic                        csr_we,
   input  logic [bam_pkg::CSR_AW-1:0]  csr_addr,
   input  logic [bam_pkg::CSR_DW-1:0]  csr_wdata
);

   bam_pkg::bam_cmd_type  cmd;
   bam_pkg::bam_stat_type stat;

   bam_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   bam_dp #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_BLOCK (MAX_BLOCK)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .pixel      (req_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[src/bam_checker.sv]
module bam_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result word stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result word dropped while stalled");

   // a stalled result word keeps its contents
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result word changed while stalled");

   // no result word right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // one pixel in flight: req_tready drops after every accept
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("pixel taken while previous one still in work");

   // a new result word never appears on the edge right after a pixel accept
   a_no_fast_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> !$past(req_tvalid && req_tready))
      else $error("result word appeared before the mean could be computed");

endmodule

bind block_average_mosaic bam_checker u_bam_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

[tb/sv/block_average_mosaic_tb.sv]
`timescale 1ns / 100ps

module block_average_mosaic_tb;

   localparam int MAX_W        = 4096;
   localparam int MAX_H        = bam_pkg::HEIGHT_MAX;
   localparam int MAX_B        = 64;
   localparam int DRAIN_CYCLES = 40;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int PHASE_CAP    = 60;
   localparam int RANDOM_BATCH = 70;
   localparam logic [bam_pkg::CSR_AW-1:0] REG_UNUSED = 2'd3;

   typedef struct packed {
      logic [7:0]  average;
      logic [11:0] block_column;
      logic [11:0] block_row;
      logic        frame_done;
   } block_mean_type;

   typedef enum logic {ROW_WRITE, ROW_PIXEL} row_kind_type;
   typedef enum int {PIX_UNIFORM, PIX_EXTREME, PIX_BRIGHT} pixel_mix_type;

   typedef struct packed {
      row_kind_type               kind;
      logic [bam_pkg::CSR_AW-1:0] addr;
      logic [bam_pkg::CSR_DW-1:0] value;
      logic [7:0]                 pixel;
      logic                       typed;
      block_mean_type             result;
   } stim_row_type;

   logic                       clock      = 1'b0;
   logic                       reset      = 1'b1;
   logic                       req_tvalid = 1'b0;
   logic                       req_tready;
   logic [7:0]                 req_tdata  = '0;
   logic                       rsp_tvalid;
   logic                       rsp_tready = 1'b0;
   logic [31:0]                rsp_tdata;
   logic                       rsp_tlast;
   logic                       csr_we     = 1'b0;
   logic [bam_pkg::CSR_AW-1:0] csr_addr   = '0;
   logic [bam_pkg::CSR_DW-1:0] csr_wdata  = '0;

   block_average_mosaic dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mosaic predictor state
   logic [bam_pkg::DIM_W-1:0]   cfg_width  = bam_pkg::WIDTH_RESET;
   logic [bam_pkg::DIM_W-1:0]   cfg_height = bam_pkg::HEIGHT_RESET;
   logic [bam_pkg::BSIZE_W-1:0] cfg_bsize  = bam_pkg::BSIZE_RESET;
   int unsigned band_sums [MAX_W];
   int unsigned pos_x, pos_y, in_col, in_row, blk_x, blk_y;

   block_mean_type pending_means [$];
   stim_row_type   directed_rows [$];
   int             mismatches    = 0;
   int             quiet_cycles  = 0;
   int             streamed      = 0;
   int             tx_idle_pct   = 22;
   int             rx_idle_pct   = 47;
   int             hold_requests = 0;
   int             holds_seen    = 0;
   int             hold_left     = 0;

   function automatic int unsigned effective(int unsigned v, int unsigned hi);
      if (v < 1) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   task automatic clear_mosaic();
      foreach (band_sums[i]) band_sums[i] = 0;
      pos_x  = 0;
      pos_y  = 0;
      in_col = 0;
      in_row = 0;
      blk_x  = 0;
      blk_y  = 0;
   endtask

   task automatic predict_block_mean(input logic [7:0] pix, output bit closed,
                                     output block_mean_type res);
      int unsigned w, h, b, x0, y0, wp, hp;
      bit end_x, end_y, col_end, row_end;
      w       = effective(cfg_width, MAX_W);
      h       = effective(cfg_height, MAX_H);
      b       = effective(cfg_bsize, MAX_B);
      end_x   = (pos_x >= w - 1);
      end_y   = (pos_y >= h - 1);
      col_end = (in_col >= b - 1) || end_x;
      row_end = (in_row >= b - 1) || end_y;
      band_sums[blk_x] += pix;
      closed = col_end && row_end;
      res    = '0;
      if (closed) begin
         x0 = blk_x * b;
         y0 = blk_y * b;
         wp = (x0 < w) ? w - x0 : 1;
         hp = (y0 < h) ? h - y0 : 1;
         if (wp > b) wp = b;
         if (hp > b) hp = b;
         res.average      = 8'(band_sums[blk_x] / (wp * hp));
         res.block_column = 12'(blk_x);
         res.block_row    = 12'(blk_y);
         res.frame_done   = end_x && end_y;
         band_sums[blk_x] = 0;
      end
      if (end_x) begin
         pos_x  = 0;
         in_col = 0;
         blk_x  = 0;
         if (end_y) begin
            clear_mosaic();
         end else begin
            pos_y++;
            if (in_row >= b - 1) begin
               in_row = 0;
               blk_y++;
            end else begin
               in_row++;
            end
         end
      end else begin
         pos_x++;
         if (in_col >= b - 1) begin
            in_col = 0;
            blk_x++;
         end else begin
            in_col++;
         end
      end
   endtask

   // called at a falling edge, returns at the falling edge after the word is taken
   task automatic send_pixel(input logic [7:0] pix, input bit typed,
                             input block_mean_type typed_res);
      block_mean_type res;
      bit closed;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pix;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_block_mean(pix, closed, res);
      if (typed) pending_means.push_back(typed_res);
      else if (closed) pending_means.push_back(res);
      @(negedge clock);
   endtask

   task automatic wait_for_drain();
      while (pending_means.size() != 0) @(negedge clock);
      // pixels that close no block may still be in flight
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [bam_pkg::CSR_AW-1:0] addr,
                            input logic [bam_pkg::CSR_DW-1:0] value);
      req_tvalid <= 1'b0;
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      case (addr)
         bam_pkg::REG_IMAGE_WIDTH:  cfg_width  = value;
         bam_pkg::REG_IMAGE_HEIGHT: cfg_height = value;
         bam_pkg::REG_BLOCK_SIZE:   cfg_bsize  = value[bam_pkg::BSIZE_W-1:0];
         default: ;
      endcase
      if (addr != REG_UNUSED) clear_mosaic();
   endtask

   task automatic stream_pixels(input int count, input pixel_mix_type mix);
      logic [7:0] pix;
      for (int i = 0; i < count; i++) begin
         case (mix)
            PIX_EXTREME: pix = $urandom_range(1) ? 8'hFF : 8'h00;
            PIX_BRIGHT:  pix = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'hFF;
            default:     pix = 8'($urandom_range(255));
         endcase
         send_pixel(pix, 1'b0, '0);
         streamed++;
      end
   endtask

   task automatic random_phase();
      bit [2:0] mask;
      int unsigned w, h, b, frame, count;
      mask = 3'($urandom_range(1, 7));
      case ($urandom_range(9))
         0:       w = 0;
         1:       w = $urandom_range(25, 90);
         default: w = $urandom_range(1, 24);
      endcase
      case ($urandom_range(9))
         0:       h = 0;
         1:       h = $urandom_range(13, 30);
         default: h = $urandom_range(1, 12);
      endcase
      case ($urandom_range(9))
         0:       b = 0;
         1:       b = $urandom_range(64, 127);
         default: b = $urandom_range(1, 9);
      endcase
      if (mask[0]) write_reg(bam_pkg::REG_IMAGE_WIDTH, bam_pkg::CSR_DW'(w));
      if (mask[1]) write_reg(bam_pkg::REG_IMAGE_HEIGHT, bam_pkg::CSR_DW'(h));
      if (mask[2]) write_reg(bam_pkg::REG_BLOCK_SIZE, bam_pkg::CSR_DW'(b));
      frame = effective(cfg_width, MAX_W) * effective(cfg_height, MAX_H);
      // mostly whole frames, sometimes cut short by the next write
      if ($urandom_range(4) == 0) count = $urandom_range(1, frame);
      else count = frame * $urandom_range(1, 2);
      if (count > PHASE_CAP) count = $urandom_range(PHASE_CAP / 2, PHASE_CAP);
      stream_pixels(count, pixel_mix_type'($urandom_range(2)));
   endtask

   task automatic add_write(input logic [bam_pkg::CSR_AW-1:0] addr,
                            input logic [bam_pkg::CSR_DW-1:0] value);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_WRITE;
      row.addr  = addr;
      row.value = value;
      directed_rows.push_back(row);
   endtask

   task automatic add_pixel(input logic [7:0] pix);
      stim_row_type row;
      row       = '0;
      row.kind  = ROW_PIXEL;
      row.pixel = pix;
      directed_rows.push_back(row);
   endtask

   task automatic add_block(input logic [7:0] pix, input logic [7:0] avg,
                            input logic [11:0] bcol, input logic [11:0] brow,
                            input logic done);
      stim_row_type row;
      row                     = '0;
      row.kind                = ROW_PIXEL;
      row.pixel               = pix;
      row.typed               = 1'b1;
      row.result.average      = avg;
      row.result.block_column = bcol;
      row.result.block_row    = brow;
      row.result.frame_done   = done;
      directed_rows.push_back(row);
   endtask

   // result side: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (holds_seen != hold_requests) begin
         holds_seen = hold_requests;
         hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin : check_results
      block_mean_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_means.size() == 0) begin
            $error("unexpected block word: tdata %h tlast %b", rsp_tdata, rsp_tlast);
            mismatches++;
         end else begin
            want = pending_means.pop_front();
            if (rsp_tdata[7:0] !== want.average) begin
               $error("average: expected %0d, got %0d", want.average, rsp_tdata[7:0]);
               mismatches++;
            end
            if (rsp_tdata[19:8] !== want.block_column) begin
               $error("block_column: expected %0d, got %0d", want.block_column,
                      rsp_tdata[19:8]);
               mismatches++;
            end
            if (rsp_tdata[31:20] !== want.block_row) begin
               $error("block_row: expected %0d, got %0d", want.block_row, rsp_tdata[31:20]);
               mismatches++;
            end
            if (rsp_tlast !== want.frame_done) begin
               $error("frame_done: expected %0d, got %0d", want.frame_done, rsp_tlast);
               mismatches++;
            end
         end
      end
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      int batch_end;

      // single-pixel blocks, then clamping of zero sizes
      add_write(bam_pkg::REG_BLOCK_SIZE, 13'd1);
      add_write(bam_pkg::REG_IMAGE_WIDTH, 13'd1);
      add_write(bam_pkg::REG_IMAGE_HEIGHT, 13'd1);
      add_block(8'h00, 8'h00, 12'd0, 12'd0, 1'b1);
      add_block(8'hFF, 8'hFF, 12'd0, 12'd0, 1'b1);
      add_write(bam_pkg::REG_IMAGE_WIDTH, 13'd0);
      add_block(8'hA5, 8'hA5, 12'd0, 12'd0, 1'b1);
      add_write(bam_pkg::REG_IMAGE_HEIGHT, 13'd0);
      add_block(8'h5A, 8'h5A, 12'd0, 12'd0, 1'b1);
      add_write(bam_pkg::REG_BLOCK_SIZE, 13'd0);
      add_block(8'h01, 8'h01, 12'd0, 12'd0, 1'b1);
      // 2x1 and 2x2 blocks, truncated mean
      add_write(bam_pkg::REG_IMAGE_WIDTH, 13'd2);
      add_write(bam_pkg::REG_BLOCK_SIZE, 13'd2);
      add_pixel(8'hFF);
      add_block(8'hFE, 8'd254, 12'd0, 12'd0, 1'b1);
      add_write(bam_pkg::REG_IMAGE_HEIGHT, 13'd2);
      add_pixel(8'hFF);
      add_pixel(8'hFF);
      add_pixel(8'hFF);
      add_block(8'hFE, 8'd254, 12'd0, 12'd0, 1'b1);
      // partial block at the right edge
      add_write(bam_pkg::REG_IMAGE_WIDTH, 13'd3);
      add_write(bam_pkg::REG_IMAGE_HEIGHT, 13'd1);
      add_pixel(8'd10);
      add_block(8'd20, 8'd15, 12'd0, 12'd0, 1'b0);
      add_block(8'd7, 8'd7, 12'd1, 12'd0, 1'b1);
      // write past the register list must not restart the frame
      add_pixel(8'd9);
      add_write(REG_UNUSED, 13'h1FFF);
      add_block(8'd11, 8'd10, 12'd0, 12'd0, 1'b0);
      add_block(8'd200, 8'd200, 12'd1, 12'd0, 1'b1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      clear_mosaic();

      // reset height and block size: a one-pixel-wide frame of 480 rows
      write_reg(bam_pkg::REG_IMAGE_WIDTH, 13'd1);
      stream_pixels(480, PIX_UNIFORM);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_WRITE) begin
            write_reg(directed_rows[i].addr, directed_rows[i].value);
         end else begin
            send_pixel(directed_rows[i].pixel, directed_rows[i].typed,
                       directed_rows[i].result);
         end
      end

      batch_end = streamed + RANDOM_BATCH;
      while (streamed < batch_end) random_phase();

      tx_idle_pct = 47;
      rx_idle_pct = 22;
      // result side holds off while pixels keep coming
      write_reg(bam_pkg::REG_IMAGE_WIDTH, 13'd6);
      write_reg(bam_pkg::REG_IMAGE_HEIGHT, 13'd5);
      write_reg(bam_pkg::REG_BLOCK_SIZE, 13'd1);
      hold_requests++;
      stream_pixels(30, PIX_UNIFORM);
      // width and block size above range: 64-pixel blocks along the widest row
      write_reg(bam_pkg::REG_IMAGE_WIDTH, 13'h1FFF);
      write_reg(bam_pkg::REG_IMAGE_HEIGHT, 13'd1);
      write_reg(bam_pkg::REG_BLOCK_SIZE, 13'h7F);
      stream_pixels(70, PIX_EXTREME);
      batch_end = streamed + RANDOM_BATCH;
      while (streamed < batch_end) random_phase();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      // height above range: one column of 64-row blocks
      write_reg(bam_pkg::REG_IMAGE_WIDTH, 13'd1);
      write_reg(bam_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
      write_reg(bam_pkg::REG_BLOCK_SIZE, 13'd64);
      stream_pixels(70, PIX_UNIFORM);
      // one large edge block, wide sum and divisor
      write_reg(bam_pkg::REG_IMAGE_WIDTH, 13'd12);
      write_reg(bam_pkg::REG_IMAGE_HEIGHT, 13'd16);
      stream_pixels(12 * 16, PIX_BRIGHT);
      batch_end = streamed + RANDOM_BATCH;
      while (streamed < batch_end) random_phase();

      req_tvalid <= 1'b0;
      wait_for_drain();
      if (mismatches == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
